// ===== rtl/sef_pkg.sv =====
package sef_pkg;

	localparam int unsigned MAX_PAYLOAD = 16384;
	localparam int unsigned MAX_HEADER  = 8;

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;

	localparam int unsigned LEN_W   = 15;
	localparam int unsigned IDX_W   = 14;
	localparam int unsigned PKLEN_W = 24;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] CFG_PACKET_ENABLE     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_PACKET_SERVICE_ID = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_LIMIT     = 2'd2;

	localparam logic [7:0]  RST_PACKET_SERVICE_ID = 8'h74;
	localparam logic [31:0] RST_TIMEOUT_LIMIT     = 32'd400000000;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_POLL    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_PAYLOAD  = 3'd1;
	localparam logic [2:0] EV_ACCEPT   = 3'd2;
	localparam logic [2:0] EV_MISMATCH = 3'd3;
	localparam logic [2:0] EV_TIMEOUT  = 3'd4;
	localparam logic [2:0] EV_BADLEN   = 3'd5;

	typedef struct packed {
		logic        packet_enable;
		logic [7:0]  packet_service_id;
		logic [31:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic             packet_attached;
		logic [31:0]      checksum;
		logic [LEN_W-1:0] packet_length;
		logic [7:0]       pkt_seq;
		logic [IDX_W-1:0] payload_index;
		logic [7:0]       payload_byte;
		logic [63:0]      header_bytes;
		logic [3:0]       msg_length;
		logic [7:0]       service_id;
	} result_t;

endpackage

// ===== rtl/soh_eot_frame_receiver.sv =====
// Channel  Direction  Handshake              Payload
// s        in         s_tvalid / s_tready    tuser: cmd; tdata: rx_byte
// m        out        m_tvalid / m_tready    tuser: event_res; tdata: frame fields
// cfg      in         cfg_we                 cfg_addr selects, cfg_wdata value
//
// One word in, one word out. A word goes into the input register, then the parser
// updates its state and fills the result register from it, both when the result
// register can take a word; throughput one word per cycle while m_tready stays high.
// A stalled result holds the input register; s_tready drops only when both are full.
// Reset clears the parser to hunting with the timeout counter at its reset limit.
module soh_eot_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  logic [1:0]                     s_tuser,  // [1:0] cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] service_id, [11:8] msg_length, [75:12] header_bytes,
	// [83:76] payload_byte, [97:84] payload_index, [105:98] pkt_seq,
	// [120:106] packet_length, [152:121] checksum, [153] packet_attached, rest zero
	output logic [159:0]                   m_tdata,
	output logic [2:0]                     m_tuser,  // [2:0] event_res
	input  logic                           cfg_we,
	input  logic [sef_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sef_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sef_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	logic    valid_s2;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;
	logic    adv;
	logic [2:0] ev;
	result_t res;
	result_t res_s2;
	logic [2:0] ev_s2;

	sef_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	sef_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.cmd       (cmd_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.event_res (ev),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
			ev_s2  <= ev;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2;
	assign m_tdata  = {6'd0, res_s2};

endmodule

// ===== rtl/sef_cfg_regs.sv =====
module sef_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sef_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sef_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output sef_pkg::cfg_t                  cfg
);
	import sef_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_enable     <= 1'b1;
			cfg_q.packet_service_id <= RST_PACKET_SERVICE_ID;
			cfg_q.timeout_limit     <= RST_TIMEOUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PACKET_ENABLE:     cfg_q.packet_enable     <= cfg_wdata[0];
				CFG_PACKET_SERVICE_ID: cfg_q.packet_service_id <= cfg_wdata[7:0];
				CFG_TIMEOUT_LIMIT:     cfg_q.timeout_limit     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sef_parser.sv =====
module sef_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [1:0]       cmd,
	input  logic [7:0]       rx_byte,
	input  sef_pkg::cfg_t    cfg,
	output logic [2:0]       event_res,
	output sef_pkg::result_t res
);
	import sef_pkg::*;

	typedef enum logic [2:0] {
		ST_HUNT = 3'd0,
		ST_SID  = 3'd1,
		ST_LEN  = 3'd2,
		ST_HDR  = 3'd3,
		ST_PAY  = 3'd4,
		ST_EOT  = 3'd5
	} state_t;

	state_t           state_q, n_state;
	logic [3:0]       rem_q, n_rem;
	logic [7:0]       sid_q, n_sid;
	logic [3:0]       flen_q, n_flen;
	logic [63:0]      hdr_q, n_hdr;
	logic [LEN_W-1:0] pos_q, n_pos;
	logic [LEN_W-1:0] elen_q, n_elen;
	logic [31:0]      eck_q, n_eck;
	logic [31:0]      run_q, n_run;
	logic [23:0]      wa_q, n_wa;
	logic [31:0]      tmo_q, n_tmo;
	logic             has_q, n_has;

	logic [2:0]         ev;
	logic [7:0]         pb;
	logic [IDX_W-1:0]   pi;
	logic [2:0]         hpos;
	logic [PKLEN_W-1:0] plen;
	logic [LEN_W-1:0]   pos_inc;

	always_comb begin
		n_state = state_q;
		n_rem   = rem_q;
		n_sid   = sid_q;
		n_flen  = flen_q;
		n_hdr   = hdr_q;
		n_pos   = pos_q;
		n_elen  = elen_q;
		n_eck   = eck_q;
		n_run   = run_q;
		n_wa    = wa_q;
		n_tmo   = tmo_q;
		n_has   = has_q;
		ev      = EV_NONE;
		pb      = 8'd0;
		pi      = '0;
		hpos    = 3'(flen_q - rem_q);
		plen    = '0;
		pos_inc = pos_q + 1'b1;

		if (cmd == CMD_RESTART) begin
			n_state = ST_HUNT;
			n_tmo   = cfg.timeout_limit;
		end else begin
			if (cmd == CMD_BYTE) begin
				unique case (state_q)
					ST_SID: begin
						n_sid   = rx_byte;
						n_state = ST_LEN;
					end
					ST_LEN: begin
						if (rx_byte == 8'd0) begin
							n_flen  = 4'd0;
							n_hdr   = '0;
							n_has   = 1'b0;
							n_state = ST_EOT;
						end else if (rx_byte <= 8'(MAX_HEADER)) begin
							n_flen  = rx_byte[3:0];
							n_rem   = rx_byte[3:0];
							n_hdr   = '0;
							n_has   = 1'b0;
							n_state = ST_HDR;
						end else begin
							n_state = ST_HUNT;
						end
					end
					ST_HDR: begin
						for (int i = 0; i < 8; i++) begin
							if (hpos == 3'(i))
								n_hdr[63-8*i -: 8] = hdr_q[63-8*i -: 8] | rx_byte;
						end
						n_rem = rem_q - 4'd1;
						if (n_rem == 4'd0) begin
							n_state = ST_EOT;
							if (cfg.packet_enable && flen_q == 4'(MAX_HEADER) &&
									sid_q == cfg.packet_service_id) begin
								plen   = n_hdr[55:32];
								n_elen = plen[LEN_W-1:0];
								n_eck  = n_hdr[31:0];
								n_run  = '0;
								n_wa   = '0;
								n_pos  = '0;
								if (plen == '0 || plen > PKLEN_W'(MAX_PAYLOAD)) begin
									ev      = EV_BADLEN;
									n_state = ST_HUNT;
								end else begin
									n_state = ST_PAY;
								end
							end
						end
					end
					ST_PAY: begin
						pb = rx_byte;
						pi = pos_q[IDX_W-1:0];
						ev = EV_PAYLOAD;
						unique case (pos_q[1:0])
							2'd0: n_wa = wa_q | {16'd0, rx_byte};
							2'd1: n_wa = wa_q | {8'd0, rx_byte, 8'd0};
							2'd2: n_wa = wa_q | {rx_byte, 16'd0};
							2'd3: begin
								n_run = run_q ^ {rx_byte, wa_q};
								n_wa  = '0;
							end
						endcase
						n_pos = pos_inc;
						if (pos_inc >= elen_q) begin
							if (n_run == eck_q) begin
								n_has   = 1'b1;
								n_state = ST_EOT;
							end else begin
								ev      = EV_MISMATCH;
								n_state = ST_HUNT;
							end
						end
					end
					ST_EOT: begin
						if (rx_byte == EOT_BYTE)
							ev = EV_ACCEPT;
						else if (rx_byte == SOH_BYTE)
							n_state = ST_SID;
						else
							n_state = ST_HUNT;
					end
					default: n_state = (rx_byte == SOH_BYTE) ? ST_SID : ST_HUNT;
				endcase
			end
			if (ev != EV_ACCEPT) begin
				if (tmo_q == 32'd0) begin
					ev = EV_TIMEOUT;
					pb = 8'd0;
					pi = '0;
				end else begin
					n_tmo = tmo_q - 32'd1;
				end
			end
			// restart after a frame or a timeout
			if (ev == EV_ACCEPT || ev == EV_TIMEOUT) begin
				n_state = ST_HUNT;
				n_tmo   = cfg.timeout_limit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			rem_q   <= '0;
			sid_q   <= '0;
			flen_q  <= '0;
			hdr_q   <= '0;
			pos_q   <= '0;
			elen_q  <= '0;
			eck_q   <= '0;
			run_q   <= '0;
			wa_q    <= '0;
			tmo_q   <= RST_TIMEOUT_LIMIT;
			has_q   <= 1'b0;
		end else if (en) begin
			state_q <= n_state;
			rem_q   <= n_rem;
			sid_q   <= n_sid;
			flen_q  <= n_flen;
			hdr_q   <= n_hdr;
			pos_q   <= n_pos;
			elen_q  <= n_elen;
			eck_q   <= n_eck;
			run_q   <= n_run;
			wa_q    <= n_wa;
			tmo_q   <= n_tmo;
			has_q   <= n_has;
		end
	end

	assign event_res           = ev;
	assign res.service_id      = n_sid;
	assign res.msg_length      = n_flen;
	assign res.header_bytes    = n_hdr;
	assign res.payload_byte    = pb;
	assign res.payload_index   = pi;
	assign res.pkt_seq         = n_hdr[63:56];
	assign res.packet_length   = n_elen;
	assign res.checksum        = n_run;
	assign res.packet_attached = n_has;

endmodule
